// File: rtl/date_string_to_day_number_assert.svh
// Assertion macros for the date string parser.
`ifndef DATE_STRING_TO_DAY_NUMBER_ASSERT_SVH
`define DATE_STRING_TO_DAY_NUMBER_ASSERT_SVH
`ifndef ASSERT_OFF
`define DSDN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define DSDN_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define DSDN_ASSERT(lbl, prop, msg)
`define DSDN_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/dsdn_pkg.sv
`default_nettype none
package dsdn_pkg;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_MAX = 4'd12;
    localparam logic [4:0] DAYS_LONG      = 5'd31;
    localparam logic [4:0] DAYS_SHORT     = 5'd30;
    localparam logic [4:0] DAYS_FEB       = 5'd28;
    localparam logic [4:0] DAYS_FEB_LEAP  = 5'd29;

    // year offset of 26 eras keeps the shifted year non-negative
    localparam logic [15:0] YEAR_SHIFT    = 16'd10400;
    localparam logic [14:0] ERA_RECIP     = 15'd20972;
    localparam int          ERA_SHIFT     = 23;
    localparam logic [8:0]  ERA_YEARS     = 9'd400;
    localparam logic [17:0] ERA_DAYS      = 18'd146097;
    localparam logic [5:0]  CENT_RECIP    = 6'd41;
    localparam int          CENT_SHIFT    = 12;
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
    localparam logic [22:0] DAY_OFFSET    = 23'd4517990;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NA      = 2'd1,
        ST_INVALID = 2'd2,
        ST_RANGE   = 2'd3
    } status_t;

    typedef struct packed {
        status_t     status;
        logic        neg;
        logic [13:0] ymag;
        logic [3:0]  month;
        logic [4:0]  day;
    } fin_t;

    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAYS_LONG;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = DAYS_SHORT;
            MONTH_FEB:                                  len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // days before the first of each month, year starting in March
    function automatic logic [8:0] days_before(input logic [3:0] mp);
        logic [8:0] d;
        case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

// File: rtl/dsdn_parser.sv
`default_nettype none
module dsdn_parser import dsdn_pkg::*; #(
    parameter int YEAR_LIMIT = 9999
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_char_code,
    input  wire logic       s_end_flag,
    input  wire logic       s_missing_string,
    output logic            fin_valid,
    input  wire logic       fin_ready,
    output fin_t            fin
);

    typedef enum logic [9:0] {
        PH_LEAD       = 10'b0000000001,
        PH_SIGN       = 10'b0000000010,
        PH_YEAR       = 10'b0000000100,
        PH_GAP1       = 10'b0000001000,
        PH_MONTH      = 10'b0000010000,
        PH_GAP2       = 10'b0000100000,
        PH_DAY        = 10'b0001000000,
        PH_TAIL_CLEAN = 10'b0010000000,
        PH_TAIL_JUNK  = 10'b0100000000,
        PH_HALT       = 10'b1000000000
    } phase_t;

    logic        strict_reg;
    phase_t      phase_reg, phase_next;
    logic [13:0] ymag_reg, ymag_next;
    logic [15:0] ydig_reg, ydig_next;
    logic        neg_reg, neg_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;
    logic        failed_reg, failed_next;
    logic        ovf_reg, ovf_next;
    logic        fin_valid_reg, fin_valid_next;
    fin_t        fin_reg, fin_next;

    logic        accept;
    logic        is_dig;
    logic        is_ws;
    logic [3:0]  dig;
    logic [16:0] year_t;
    logic [7:0]  month_t;
    logic [8:0]  day_t;
    logic        leap;
    logic [1:0]  cent_mod4;
    logic        string_ok;

    assign s_ready   = !fin_valid_reg || fin_ready;
    assign accept    = s_valid && s_ready;
    assign fin_valid = fin_valid_reg;
    assign fin       = fin_reg;

    assign is_dig  = s_char_code inside {[CH_ZERO:CH_NINE]};
    assign is_ws   = (s_char_code == CH_SPACE) || (s_char_code inside {[CH_TAB:CH_CR]});
    assign dig     = s_char_code[3:0];
    assign year_t  = 17'(ymag_reg) * 17'd10 + 17'(dig);
    assign month_t = 8'(month_reg) * 8'd10 + 8'(dig);
    assign day_t   = (phase_reg == PH_GAP2) ? 9'(dig) : 9'(day_reg) * 9'd10 + 9'(dig);

    // leap test from the last four decimal year digits
    assign cent_mod4 = {ydig_reg[12], 1'b0} + ydig_reg[9:8];
    assign leap = (ymag_reg[1:0] == 2'd0)
                  && ((ydig_reg[7:0] != 8'd0) || (cent_mod4 == 2'd0));

    assign string_ok = ((phase_reg == PH_DAY) && (day_reg != 5'd0))
                       || (phase_reg == PH_TAIL_CLEAN)
                       || ((phase_reg == PH_TAIL_JUNK) && !strict_reg);

    always_comb begin
        phase_next     = phase_reg;
        ymag_next      = ymag_reg;
        ydig_next      = ydig_reg;
        neg_next       = neg_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        failed_next    = failed_reg;
        ovf_next       = ovf_reg;
        fin_valid_next = fin_valid_reg && !fin_ready;
        fin_next       = fin_reg;
        if (accept) begin
            if (s_end_flag) begin
                fin_valid_next = 1'b1;
                fin_next.neg   = neg_reg;
                fin_next.ymag  = ymag_reg;
                fin_next.month = month_reg;
                fin_next.day   = day_reg;
                if (s_missing_string) begin
                    fin_next.status = ST_NA;
                end else if (ovf_reg) begin
                    fin_next.status = ST_RANGE;
                end else if (failed_reg || !string_ok) begin
                    fin_next.status = ST_INVALID;
                end else begin
                    fin_next.status = ST_OK;
                end
                phase_next  = PH_LEAD;
                ymag_next   = 14'd0;
                ydig_next   = 16'd0;
                neg_next    = 1'b0;
                month_next  = 4'd0;
                day_next    = 5'd0;
                failed_next = 1'b0;
                ovf_next    = 1'b0;
            end else begin
                case (phase_reg)
                    PH_LEAD, PH_SIGN: begin
                        if (is_dig) begin
                            ymag_next  = 14'(dig);
                            ydig_next  = {12'd0, dig};
                            phase_next = PH_YEAR;
                        end else if ((phase_reg == PH_LEAD) && is_ws) begin
                            phase_next = PH_LEAD;
                        end else if ((phase_reg == PH_LEAD) && (s_char_code == CH_MINUS)) begin
                            neg_next   = 1'b1;
                            phase_next = PH_SIGN;
                        end else begin
                            failed_next = 1'b1;
                            phase_next  = PH_HALT;
                        end
                    end
                    PH_YEAR: begin
                        if (is_dig) begin
                            if (year_t > 17'(YEAR_LIMIT)) begin
                                ovf_next   = 1'b1;
                                phase_next = PH_HALT;
                            end else begin
                                ymag_next = year_t[13:0];
                                ydig_next = {ydig_reg[11:0], dig};
                            end
                        end else begin
                            phase_next = PH_GAP1;
                        end
                    end
                    PH_GAP1: begin
                        if (is_dig) begin
                            month_next = dig;
                            phase_next = PH_MONTH;
                        end
                    end
                    PH_MONTH: begin
                        if (is_dig) begin
                            if (month_t > 8'(MONTH_MAX)) begin
                                failed_next = 1'b1;
                                phase_next  = PH_HALT;
                            end else begin
                                month_next = month_t[3:0];
                            end
                        end else if (month_reg == 4'd0) begin
                            failed_next = 1'b1;
                            phase_next  = PH_HALT;
                        end else begin
                            phase_next = PH_GAP2;
                        end
                    end
                    PH_GAP2, PH_DAY: begin
                        if (is_dig) begin
                            if (day_t > 9'(month_days(month_reg, leap))) begin
                                failed_next = 1'b1;
                                phase_next  = PH_HALT;
                            end else begin
                                day_next   = day_t[4:0];
                                phase_next = PH_DAY;
                            end
                        end else if (phase_reg == PH_DAY) begin
                            if (day_reg == 5'd0) begin
                                failed_next = 1'b1;
                                phase_next  = PH_HALT;
                            end else begin
                                phase_next = is_ws ? PH_TAIL_CLEAN : PH_TAIL_JUNK;
                            end
                        end
                    end
                    PH_TAIL_CLEAN: begin
                        if (!is_ws) begin
                            phase_next = PH_TAIL_JUNK;
                        end
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strict_reg    <= 1'b1;
            phase_reg     <= PH_LEAD;
            ymag_reg      <= 14'd0;
            ydig_reg      <= 16'd0;
            neg_reg       <= 1'b0;
            month_reg     <= 4'd0;
            day_reg       <= 5'd0;
            failed_reg    <= 1'b0;
            ovf_reg       <= 1'b0;
            fin_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                strict_reg <= cfg_wr_data;
            end
            phase_reg     <= phase_next;
            ymag_reg      <= ymag_next;
            ydig_reg      <= ydig_next;
            neg_reg       <= neg_next;
            month_reg     <= month_next;
            day_reg       <= day_next;
            failed_reg    <= failed_next;
            ovf_reg       <= ovf_next;
            fin_valid_reg <= fin_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fin_reg <= fin_next;
    end

endmodule
`default_nettype wire

// File: rtl/dsdn_days.sv
`default_nettype none
module dsdn_days import dsdn_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         fin_valid,
    output logic              fin_ready,
    input  wire fin_t         fin,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic signed [23:0] m_day_number,
    output logic [1:0]        m_status
);

    // stage a: shifted year, era product, day of year
    logic        a_valid_reg;
    logic [14:0] a_yadj_reg, a_yadj_next;
    logic [29:0] a_prod_reg, a_prod_next;
    logic [8:0]  a_doy_reg, a_doy_next;
    status_t     a_status_reg;
    // stage b: era and year of era
    logic        b_valid_reg;
    logic [5:0]  b_era_reg, b_era_next;
    logic [8:0]  b_yoe_reg, b_yoe_next;
    logic [8:0]  b_doy_reg;
    status_t     b_status_reg;
    // stage c: era days and day of era
    logic        c_valid_reg;
    logic [22:0] c_ep_reg, c_ep_next;
    logic [17:0] c_doe_reg, c_doe_next;
    status_t     c_status_reg;
    // result register
    logic              out_valid_reg;
    logic signed [23:0] out_days_reg, out_days_next;
    status_t           out_status_reg;

    logic        out_free, c_free, b_free, a_free;
    logic        feb_or_jan;
    logic [15:0] yabs;
    logic [15:0] yadj;
    logic [3:0]  mp;
    logic [13:0] cent_prod;
    logic [24:0] day_sum;

    assign out_free  = !out_valid_reg || m_ready;
    assign c_free    = !c_valid_reg || out_free;
    assign b_free    = !b_valid_reg || c_free;
    assign a_free    = !a_valid_reg || b_free;
    assign fin_ready = a_free;

    always_comb begin
        feb_or_jan  = fin.month <= MONTH_FEB;
        yabs        = {2'b00, fin.ymag};
        yadj        = YEAR_SHIFT - 16'(feb_or_jan) + (fin.neg ? 16'd0 - yabs : yabs);
        a_yadj_next = yadj[14:0];
        a_prod_next = 30'(a_yadj_next) * 30'(ERA_RECIP);
        mp          = feb_or_jan ? fin.month + 4'd9 : fin.month - 4'd3;
        a_doy_next  = days_before(mp) + 9'(fin.day) - 9'd1;

        b_era_next  = 6'(a_prod_reg >> ERA_SHIFT);
        b_yoe_next  = 9'(a_yadj_reg - 15'(b_era_next) * 15'(ERA_YEARS));

        c_ep_next   = 23'(b_era_reg) * 23'(ERA_DAYS);
        cent_prod   = 14'(b_yoe_reg) * 14'(CENT_RECIP);
        c_doe_next  = 18'(b_yoe_reg) * 18'(DAYS_PER_YEAR) + 18'(b_yoe_reg >> 2)
                      - 18'(cent_prod >> CENT_SHIFT) + 18'(b_doy_reg);

        day_sum       = 25'(c_ep_reg) + 25'(c_doe_reg) - 25'(DAY_OFFSET);
        out_days_next = (c_status_reg == ST_OK) ? $signed(day_sum[23:0]) : 24'sd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (a_free) begin
                a_valid_reg <= fin_valid;
            end
            if (b_free) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_free) begin
                c_valid_reg <= b_valid_reg;
            end
            if (out_free) begin
                out_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_free && fin_valid) begin
            a_yadj_reg   <= a_yadj_next;
            a_prod_reg   <= a_prod_next;
            a_doy_reg    <= a_doy_next;
            a_status_reg <= fin.status;
        end
        if (b_free && a_valid_reg) begin
            b_era_reg    <= b_era_next;
            b_yoe_reg    <= b_yoe_next;
            b_doy_reg    <= a_doy_reg;
            b_status_reg <= a_status_reg;
        end
        if (c_free && b_valid_reg) begin
            c_ep_reg     <= c_ep_next;
            c_doe_reg    <= c_doe_next;
            c_status_reg <= b_status_reg;
        end
        if (out_free && c_valid_reg) begin
            out_days_reg   <= out_days_next;
            out_status_reg <= c_status_reg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_day_number = out_days_reg;
    assign m_status     = out_status_reg;

endmodule
`default_nettype wire

// File: rtl/date_string_to_day_number.sv
`default_nettype none
// Date string to day number. Bytes of a date string ("[-]Y...Y?M?D") arrive one per
// request; a request with s_end_flag set ends the string and yields one result: the
// day count since 1970-01-01 (proleptic Gregorian) with m_status 0, or m_status 1 (NA),
// 2 (invalid string) or 3 (year beyond YEAR_LIMIT) with m_day_number 0. One request
// is taken every cycle while s_ready is high (m_ready back-pressure can drop it); the
// parser updates its state once per byte and the day count runs through a four-stage
// pipeline behind the parser's result register. cfg_wr_en/cfg_wr_data write strict
// mode (reset 1), which rejects anything but whitespace after the day digits.
`include "date_string_to_day_number_assert.svh"
module date_string_to_day_number import dsdn_pkg::*; #(
    parameter int YEAR_LIMIT = 9999
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic         cfg_wr_data,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [7:0]   s_char_code,
    input  wire logic         s_end_flag,
    input  wire logic         s_missing_string,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic signed [23:0] m_day_number,
    output logic [1:0]        m_status
);

    logic fin_valid;
    logic fin_ready;
    fin_t fin;

    dsdn_parser #(
        .YEAR_LIMIT(YEAR_LIMIT)
    ) u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_code     (s_char_code),
        .s_end_flag      (s_end_flag),
        .s_missing_string(s_missing_string),
        .fin_valid       (fin_valid),
        .fin_ready       (fin_ready),
        .fin             (fin)
    );

    dsdn_days u_days (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fin_valid   (fin_valid),
        .fin_ready   (fin_ready),
        .fin         (fin),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_day_number(m_day_number),
        .m_status    (m_status)
    );

    `DSDN_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")
    `DSDN_ASSERT(a_idle_ready, !m_valid |-> s_ready, "request refused with empty output")
    `DSDN_ASSERT(a_fail_zero, (m_valid && m_status != ST_OK) |-> (m_day_number == 24'sd0),
        "nonzero day number on failed string")
    `DSDN_ASSERT(a_day_range, (m_valid && m_status == ST_OK)
        |-> (m_day_number >= -24'sd4400000 && m_day_number <= 24'sd2932896),
        "day number out of range")

endmodule
`default_nettype wire
